/* sv/gpio_port_register_block_macros.svh */
// Assertion helpers for the GPIO port register block.
`ifndef GPIO_PORT_REGISTER_BLOCK_MACROS_SVH
`define GPIO_PORT_REGISTER_BLOCK_MACROS_SVH

// Clocked check, held off while in reset
`define GPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset
`define GPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/gpio_prb_pkg.sv */
package gpio_prb_pkg;

    // Access kind carried on the input tuser
    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    localparam int unsigned PIN_MAX      = 64;
    localparam int unsigned FSEL_WORDS   = 6;
    localparam int unsigned PINS_PER_SEL = 10;
    localparam int unsigned SEL_BITS     = 3;

    // Word addresses
    localparam logic [5:0] ADDR_FSEL_FIRST = 6'd0;
    localparam logic [5:0] ADDR_FSEL_LAST  = 6'd5;
    localparam logic [5:0] ADDR_SET_LO     = 6'd7;
    localparam logic [5:0] ADDR_SET_HI     = 6'd8;
    localparam logic [5:0] ADDR_CLR_LO     = 6'd10;
    localparam logic [5:0] ADDR_CLR_HI     = 6'd11;
    localparam logic [5:0] ADDR_LEV_LO     = 6'd13;
    localparam logic [5:0] ADDR_LEV_HI     = 6'd14;
    localparam logic [5:0] ADDR_PULL_CTL   = 6'd37;
    localparam logic [5:0] ADDR_PULL_CLK_LO = 6'd38;
    localparam logic [5:0] ADDR_PULL_CLK_HI = 6'd39;

    // Function select codes
    localparam logic [2:0] SEL_INPUT  = 3'b000;
    localparam logic [2:0] SEL_OUTPUT = 3'b001;

    // Pull settings
    localparam logic [1:0] PULL_NONE = 2'd0;
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

endpackage

/* sv/gpio_port_register_block.sv */
// GPIO port register block: each input item is one 32-bit register access (read or
// write, word address, write data and the sampled pad levels); each result item holds
// the read data and the pin controls (drive level, drive enable, pull masks) as they
// stand after the access. One item per clock is sustained while results are taken; an
// item goes through an input register and a result register, and the input register
// lets one item in while a result is stalled. Pins at or above PIN_COUNT hold no
// state and read and drive zero; select code 001 makes a pin drive. Pull settings are
// latched per pin from the pull-control word.
`include "gpio_port_register_block_macros.svh"

module gpio_port_register_block
    import gpio_prb_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 54
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // func
    input  logic [103:0] s_tdata,   // word_addr[5:0], write_data[37:6], pad_levels[101:38]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata    // read_data[31:0], drive_levels[95:32],
                                    // drive_enable[159:96], pull_down_mask[223:160],
                                    // pull_up_mask[287:224]
);

    localparam logic [63:0] PRESENT = (PIN_COUNT >= PIN_MAX) ? {64{1'b1}} :
                                      ((64'd1 << PIN_COUNT) - 64'd1);

    // Input stage
    logic        in_valid_reg, in_valid_next;
    func_t       in_func_reg;
    logic [5:0]  in_addr_reg;
    logic [31:0] in_wdata_reg;
    logic [63:0] in_pads_reg;

    // Block state
    logic [29:0] fsel_reg [FSEL_WORDS];
    logic [29:0] fsel_next [FSEL_WORDS];
    logic [63:0] latch_reg, latch_next;
    logic [1:0]  pull_ctl_reg, pull_ctl_next;
    logic [1:0]  pin_pull_reg [PIN_MAX];
    logic [1:0]  pin_pull_next [PIN_MAX];

    // Result stage
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_rd_reg;
    logic [63:0] out_lev_reg, out_en_reg, out_dn_reg, out_up_reg;

    logic        advance, load, accept, wr;
    logic [29:0] sel_mask [FSEL_WORDS];
    logic [63:0] pads, hit;
    logic [31:0] rd;
    logic [63:0] en, dn, up;

    // Handshake
    assign advance  = !out_valid_reg || m_tready;
    assign load     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_up_reg, out_dn_reg, out_en_reg, out_lev_reg, out_rd_reg};

    always_comb begin
        in_valid_next  = accept ? 1'b1 : (load ? 1'b0 : in_valid_reg);
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Select field masks for present pins
    always_comb begin
        for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < PINS_PER_SEL; k++) begin
                sel_mask[w][SEL_BITS*k +: SEL_BITS] = {SEL_BITS{PRESENT[w*PINS_PER_SEL + k]}};
            end
        end
    end

    // Register decode and state update
    always_comb begin
        wr            = (in_func_reg == FUNC_WRITE);
        pads          = in_pads_reg & PRESENT;
        rd            = '0;
        hit           = '0;
        fsel_next     = fsel_reg;
        latch_next    = latch_reg;
        pull_ctl_next = pull_ctl_reg;
        pin_pull_next = pin_pull_reg;
        unique case (in_addr_reg) inside
            [ADDR_FSEL_FIRST:ADDR_FSEL_LAST]: begin
                if (wr) begin
                    fsel_next[in_addr_reg[2:0]] = in_wdata_reg[29:0] & sel_mask[in_addr_reg[2:0]];
                end else begin
                    rd = {2'b00, fsel_reg[in_addr_reg[2:0]]};
                end
            end
            ADDR_SET_LO: if (wr) latch_next = latch_reg | ({32'd0, in_wdata_reg} & PRESENT);
            ADDR_SET_HI: if (wr) latch_next = latch_reg | ({in_wdata_reg, 32'd0} & PRESENT);
            ADDR_CLR_LO: if (wr) latch_next = latch_reg & ~({32'd0, in_wdata_reg} & PRESENT);
            ADDR_CLR_HI: if (wr) latch_next = latch_reg & ~({in_wdata_reg, 32'd0} & PRESENT);
            ADDR_LEV_LO: if (!wr) rd = pads[31:0];
            ADDR_LEV_HI: if (!wr) rd = pads[63:32];
            ADDR_PULL_CTL: begin
                if (wr) begin
                    pull_ctl_next = in_wdata_reg[1:0];
                end else begin
                    rd = {30'd0, pull_ctl_reg};
                end
            end
            ADDR_PULL_CLK_LO: if (wr) hit = {32'd0, in_wdata_reg} & PRESENT;
            ADDR_PULL_CLK_HI: if (wr) hit = {in_wdata_reg, 32'd0} & PRESENT;
            default: ;
        endcase
        for (int n = 0; n < PIN_MAX; n++) begin
            if (hit[n]) pin_pull_next[n] = pull_ctl_reg;
        end
    end

    // Pin control outputs from the updated state
    always_comb begin
        en = '0;
        for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < PINS_PER_SEL; k++) begin
                en[w*PINS_PER_SEL + k] =
                    (fsel_next[w][SEL_BITS*k +: SEL_BITS] == SEL_OUTPUT);
            end
        end
        for (int n = 0; n < PIN_MAX; n++) begin
            dn[n] = (pin_pull_next[n] == PULL_DOWN);
            up[n] = (pin_pull_next[n] == PULL_UP);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= '0;
            pull_ctl_reg  <= PULL_NONE;
            for (int w = 0; w < FSEL_WORDS; w++) fsel_reg[w] <= {PINS_PER_SEL{SEL_INPUT}};
            for (int n = 0; n < PIN_MAX; n++) pin_pull_reg[n] <= PULL_NONE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                latch_reg    <= latch_next;
                pull_ctl_reg <= pull_ctl_next;
                fsel_reg     <= fsel_next;
                pin_pull_reg <= pin_pull_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_func_reg  <= func_t'(s_tuser);
            in_addr_reg  <= s_tdata[5:0];
            in_wdata_reg <= s_tdata[37:6];
            in_pads_reg  <= s_tdata[101:38];
        end
        if (load) begin
            out_rd_reg  <= rd;
            out_lev_reg <= latch_next;
            out_en_reg  <= en;
            out_dn_reg  <= dn;
            out_up_reg  <= up;
        end
    end

    // Checks
    `GPR_ASSERT(a_absent_pins_idle,
        out_valid_reg |-> (((out_lev_reg | out_en_reg) & ~PRESENT) == 64'd0),
        "absent pin drives")
    `GPR_ASSERT(a_pull_masks_disjoint,
        out_valid_reg |-> ((out_dn_reg & out_up_reg) == 64'd0),
        "pin pulled both ways")
    `GPR_ASSERT(a_load_gives_result,
        load |=> out_valid_reg,
        "loaded item produced no result")
    `GPR_ASSERT_ALWAYS(a_reset_empties,
        !aresetn |=> (!in_valid_reg && !out_valid_reg),
        "stage valid after reset")

endmodule
